FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true on a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/pcg_pkg.sv
// ----------------------------------------------------------------------------
// pcg_pkg
// Shared types and constants of the pixel cluster grower.
// ----------------------------------------------------------------------------
package pcg_pkg;

	localparam int MaxMembersDefault = 64;
	localparam int CoordBitsDefault  = 16;

	localparam logic [2:0] StAccepted     = 3'd0;
	localparam logic [2:0] StInvalidId    = 3'd1;
	localparam logic [2:0] StDuplicate    = 3'd2;
	localparam logic [2:0] StNotNeighbour = 3'd3;
	localparam logic [2:0] StStoreFull    = 3'd4;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_UPDATE,
		S_DIV,
		S_OUT
	} state_t;

	// Request to the divider and its busy flag.
	typedef struct packed {
		logic start;
		logic busy;
	} div_ctl_t;

endpackage

FILE: rtl/pixel_cluster_grower_top.sv
// ----------------------------------------------------------------------------
// pixel_cluster_grower_top
// Grows one pixel cluster and reports its centroid after every pixel.
// ----------------------------------------------------------------------------
// Input pixels arrive on the s_axis channel, one result per pixel leaves on
// m_axis. The search_pattern register selects four- or eight-connected
// neighbours and is written through cfg_we/cfg_wdata; the user must write
// it only while the block is idle, the block itself does not enforce this.
// Each pixel first scans the stored members, one memory read per cycle. The
// three divisions (centroid x, centroid y, leader ratio) share one
// bit-serial divider of 2*COORD_BITS+16 bits, one quotient bit per cycle,
// run one after another, and are skipped when the signal sum is zero. One
// pixel is handled at a time; s_axis_tready is high only while the block is
// idle. A result holds in the output register while the receiver stalls.
// The block goes idle at the same clock edge that loads a result, so the
// next pixel is processed while that result waits; its own result then
// waits in the final state until the output register is free. Reset empties
// the cluster and clears search_pattern; the member memory needs no
// clearing since only entries below the count are read.
// ----------------------------------------------------------------------------
module pixel_cluster_grower_top #(
	parameter int MAX_MEMBERS = pcg_pkg::MaxMembersDefault,
	parameter int COORD_BITS  = pcg_pkg::CoordBitsDefault
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic                      cfg_wdata,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	// pixel_id, pixel_col, pixel_row, pos_x, pos_y, amplitude
	input  logic [((2*COORD_BITS+36)+7)/8*8-1:0] s_axis_tdata,
	// first_of_cluster
	input  logic                      s_axis_tuser,
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	// status, member_count, signal_sum, centroid_x, centroid_y, offset_x,
	// offset_y, leader_ratio, sum_is_zero, zero padded to whole bytes
	output logic [((4*COORD_BITS+$clog2(MAX_MEMBERS+1)+44)+7)/8*8-1:0] m_axis_tdata
);

	localparam int AW   = $clog2(MAX_MEMBERS);
	localparam int CW   = $clog2(MAX_MEMBERS + 1);
	localparam int CB   = COORD_BITS;
	localparam int WB   = CB + 22;
	localparam int DB   = 2 * CB + 16;
	localparam int OutW = 4 * CB + CW + 44;
	localparam int TdW  = (OutW + 7) / 8 * 8;

	logic [7:0]    in_id;
	logic [5:0]    in_col, in_row;
	logic [CB-1:0] in_x, in_y;
	logic [15:0]   in_amp;
	assign in_id  = s_axis_tdata[7:0];
	assign in_col = s_axis_tdata[13:8];
	assign in_row = s_axis_tdata[19:14];
	assign in_x   = s_axis_tdata[20 +: CB];
	assign in_y   = s_axis_tdata[20+CB +: CB];
	assign in_amp = s_axis_tdata[20+2*CB +: 16];

	pcg_pkg::state_t state_q, state_nx;

	logic          pattern_q;
	logic [7:0]    id_q;
	logic [5:0]    col_q, row_q;
	logic [CB-1:0] x_q, y_q;
	logic [15:0]   amp_q;
	logic [CW-1:0] total_q;
	logic [21:0]   sum_q;
	logic [WB-1:0] wx_q, wy_q;
	logic [15:0]   lamp_q;
	logic [CB-1:0] lx_q, ly_q;
	logic          dup_q, nb_q;
	logic [CW-1:0] rd_idx_q;
	logic          rd_vld_s1;
	logic [1:0]    div_sel_q;
	logic          div_wait_q;
	logic [2:0]    status_q;
	logic [CB-1:0] cx_q, cy_q;
	logic [15:0]   ratio_q;
	logic [TdW-1:0] out_q;
	logic          out_vld_q;

	logic          accept, out_take, scan_done;
	logic [19:0]   rd_data;
	logic [5:0]    m_col, m_row;
	logic [6:0]    dc, dr;
	logic          hit_nb;
	logic          wr_en;
	logic [DB-1:0] div_dividend;
	logic [DB-1:0] quotient;
	logic          div_busy;
	logic          div_neg;
	logic [WB-1:0] div_w;
	logic [WB-1:0] div_abs;
	logic [DB-1:0] quo_signed;
	pcg_pkg::div_ctl_t div_ctl;
	logic [CB+16:0] mul_x, mul_y;

	assign accept   = s_axis_tvalid && s_axis_tready;
	assign out_take = m_axis_tvalid && m_axis_tready;
	assign s_axis_tready = (state_q == pcg_pkg::S_IDLE);
	assign scan_done = (rd_idx_q == total_q) && !rd_vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= 1'b0;
		end else if (cfg_we) begin
			pattern_q <= cfg_wdata;
		end
	end

	pcg_member_store #(.MaxMembers(MAX_MEMBERS)) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(total_q[AW-1:0]),
		.wr_data({id_q, col_q, row_q}),
		.rd_addr(rd_idx_q[AW-1:0]),
		.rd_data(rd_data)
	);

	assign m_col = rd_data[11:6];
	assign m_row = rd_data[5:0];
	assign dc = (m_col >= col_q) ? {1'b0, m_col - col_q} : {1'b0, col_q - m_col};
	assign dr = (m_row >= row_q) ? {1'b0, m_row - row_q} : {1'b0, row_q - m_row};
	assign hit_nb = pattern_q ? (dc < 7'd2 && dr < 7'd2) : (dc + dr == 7'd1);

	assign wr_en = (state_q == pcg_pkg::S_UPDATE) && (status_q == pcg_pkg::StAccepted);

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			pcg_pkg::S_IDLE:   if (accept) state_nx = pcg_pkg::S_SCAN;
			pcg_pkg::S_SCAN:   if (scan_done) state_nx = pcg_pkg::S_UPDATE;
			pcg_pkg::S_UPDATE: state_nx = pcg_pkg::S_DIV;
			pcg_pkg::S_DIV:
				if (!div_busy && !div_wait_q && div_sel_q == 2'd3) state_nx = pcg_pkg::S_OUT;
			pcg_pkg::S_OUT:    if (!out_vld_q || out_take) state_nx = pcg_pkg::S_IDLE;
			default:           state_nx = pcg_pkg::S_IDLE;
		endcase
	end

	// Divider operands: sign-magnitude for the weighted sums, leader << 16 for the ratio.
	always_comb begin
		div_w = (div_sel_q == 2'd0) ? wx_q : wy_q;
		div_neg = div_w[WB-1] && (div_sel_q != 2'd2);
		div_abs = div_w[WB-1] ? (~div_w + 1'b1) : div_w;
		if (div_sel_q == 2'd2) begin
			div_dividend = DB'({lamp_q, 16'h0});
		end else begin
			div_dividend = DB'(div_abs);
		end
		quo_signed = div_neg ? (~quotient + 1'b1) : quotient;
		div_ctl.start = (state_q == pcg_pkg::S_DIV) && !div_busy && !div_wait_q
			&& div_sel_q != 2'd3 && sum_q != '0;
		div_ctl.busy = div_busy;
	end

	pcg_divider #(.NumBits(DB)) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_ctl.start),
		.dividend(div_dividend),
		.divisor (sum_q),
		.busy    (div_busy),
		.quotient(quotient)
	);

	assign mul_x = $signed(x_q) * $signed({1'b0, amp_q});
	assign mul_y = $signed(y_q) * $signed({1'b0, amp_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= pcg_pkg::S_IDLE;
			total_q    <= '0;
			sum_q      <= '0;
			wx_q       <= '0;
			wy_q       <= '0;
			lamp_q     <= '0;
			lx_q       <= '0;
			ly_q       <= '0;
			out_vld_q  <= 1'b0;
			rd_vld_s1  <= 1'b0;
			rd_idx_q   <= '0;
			div_sel_q  <= '0;
			div_wait_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == pcg_pkg::S_OUT && (!out_vld_q || out_take)) begin
				out_vld_q <= 1'b1;
			end else if (out_take) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				pcg_pkg::S_IDLE: begin
					if (accept) begin
						if (s_axis_tuser) begin
							total_q <= '0;
							sum_q   <= '0;
							wx_q    <= '0;
							wy_q    <= '0;
							lamp_q  <= '0;
							lx_q    <= '0;
							ly_q    <= '0;
						end
						rd_idx_q  <= '0;
						rd_vld_s1 <= 1'b0;
					end
				end
				pcg_pkg::S_SCAN: begin
					rd_vld_s1 <= (rd_idx_q != total_q);
					if (rd_idx_q != total_q) rd_idx_q <= rd_idx_q + 1'b1;
				end
				pcg_pkg::S_UPDATE: begin
					div_sel_q  <= '0;
					div_wait_q <= 1'b0;
					if (status_q == pcg_pkg::StAccepted) begin
						total_q <= total_q + 1'b1;
						sum_q   <= sum_q + 22'(amp_q);
						wx_q    <= wx_q + WB'($signed(mul_x));
						wy_q    <= wy_q + WB'($signed(mul_y));
						if (total_q == '0 || amp_q > lamp_q) begin
							lamp_q <= amp_q;
							lx_q   <= x_q;
							ly_q   <= y_q;
						end
					end
				end
				pcg_pkg::S_DIV: begin
					if (sum_q == '0) begin
						div_sel_q <= 2'd3;
					end else if (div_ctl.start) begin
						div_wait_q <= 1'b1;
					end else if (div_wait_q && !div_busy) begin
						div_wait_q <= 1'b0;
						div_sel_q  <= div_sel_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			id_q  <= in_id;
			col_q <= in_col;
			row_q <= in_row;
			x_q   <= in_x;
			y_q   <= in_y;
			amp_q <= in_amp;
			dup_q <= 1'b0;
			nb_q  <= 1'b0;
		end
		if (state_q == pcg_pkg::S_SCAN && rd_vld_s1) begin
			if (rd_data[19:12] == id_q) dup_q <= 1'b1;
			if (hit_nb) nb_q <= 1'b1;
		end
		if (state_q == pcg_pkg::S_SCAN && scan_done) begin
			if (id_q == 8'd0) status_q <= pcg_pkg::StInvalidId;
			else if (dup_q) status_q <= pcg_pkg::StDuplicate;
			else if (!(nb_q || total_q == '0)) status_q <= pcg_pkg::StNotNeighbour;
			else if (total_q >= CW'(MAX_MEMBERS)) status_q <= pcg_pkg::StStoreFull;
			else status_q <= pcg_pkg::StAccepted;
		end
		if (state_q == pcg_pkg::S_UPDATE) begin
			cx_q    <= '0;
			cy_q    <= '0;
			ratio_q <= '0;
		end
		if (state_q == pcg_pkg::S_DIV && div_wait_q && !div_busy) begin
			case (div_sel_q)
				2'd0: cx_q <= quo_signed[CB-1:0];
				2'd1: cy_q <= quo_signed[CB-1:0];
				default: ratio_q <= (quotient > DB'(16'hFFFF)) ? 16'hFFFF : quotient[15:0];
			endcase
		end
		if (state_q == pcg_pkg::S_OUT && (!out_vld_q || out_take)) begin
			out_q <= TdW'({
				(sum_q == '0),
				ratio_q,
				(sum_q == '0) ? {(CB+1){1'b0}}
					: ({cy_q[CB-1], cy_q} - {ly_q[CB-1], ly_q}),
				(sum_q == '0) ? {(CB+1){1'b0}}
					: ({cx_q[CB-1], cx_q} - {lx_q[CB-1], lx_q}),
				cy_q, cx_q, sum_q, total_q, status_q});
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_q;

endmodule

FILE: rtl/pcg_divider.sv
// ----------------------------------------------------------------------------
// pcg_divider
// Restoring divider for an unsigned dividend over a 22-bit divisor,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pcg_divider #(
	parameter int NumBits = 48
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [NumBits-1:0] dividend,
	input  logic [21:0]        divisor,
	output logic               busy,
	output logic [NumBits-1:0] quotient
);

	localparam int CntBits = $clog2(NumBits + 1);

	logic [NumBits-1:0] quo_q;
	logic [22:0]        rem_q;
	logic [21:0]        dvs_q;
	logic [CntBits-1:0] cnt_q;
	logic [23:0]        trial;
	logic [22:0]        shifted;

	assign shifted = {rem_q[21:0], quo_q[NumBits-1]};
	assign trial   = {1'b0, shifted} - {2'b00, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CntBits'(NumBits);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			if (!trial[23]) begin
				rem_q <= trial[22:0];
				quo_q <= {quo_q[NumBits-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[NumBits-2:0], 1'b0};
			end
		end
	end

	assign busy     = (cnt_q != '0);
	assign quotient = quo_q;

endmodule

FILE: rtl/pcg_member_store.sv
// ----------------------------------------------------------------------------
// pcg_member_store
// Member memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module pcg_member_store #(
	parameter int MaxMembers = pcg_pkg::MaxMembersDefault
) (
	input  logic                          clk,
	input  logic                          wr_en,
	input  logic [$clog2(MaxMembers)-1:0] wr_addr,
	input  logic [19:0]                   wr_data,
	input  logic [$clog2(MaxMembers)-1:0] rd_addr,
	output logic [19:0]                   rd_data
);

	logic [19:0] mem [MaxMembers];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

FILE: rtl/pcg_checker.sv
// ----------------------------------------------------------------------------
// pcg_checker
// Port-level checks of the pixel cluster grower, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pcg_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_axis_tvalid,
	input logic       s_axis_tready,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [2:0] st
);

	`ASSERT_IMPL(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped")
	`ASSERT_IMPL(a_busy_after_accept, clk, arst_n, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "taken while busy")
	`ASSERT_NEVER(a_status_range, clk, arst_n, m_axis_tvalid && st > 3'd4, "status code out of range")

endmodule

bind pixel_cluster_grower_top pcg_checker u_pcg_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.st           (m_axis_tdata[2:0])
);

FILE: test/pixel_cluster_grower_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_cluster_grower_top_tb
// Self-checking testbench for the pixel cluster grower.
// ----------------------------------------------------------------------------
// Pixels are sent on s_axis and a cluster predictor kept in the testbench
// works out the status and cluster summary for each one. Every result taken
// from m_axis is compared field by field with the oldest prediction. Directed
// tests cover the seed pixel, every rejection, the neighbour rules in both
// modes and a full store. Random clusters then run under several idle and
// stall mixes and both neighbour settings.
// ----------------------------------------------------------------------------
module pixel_cluster_grower_top_tb;

	localparam int  MembersMax = 64;
	localparam int  InWidth    = (2*16+36+7)/8*8;
	localparam int  OutWidth   = 120;
	localparam longint CycleLimit = 3000000;

	typedef struct {
		logic               first;
		logic [7:0]         id;
		logic [5:0]         col;
		logic [5:0]         row;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [15:0]        amp;
	} pixel_t;

	typedef struct packed {
		logic               zero;
		logic [15:0]        ratio;
		logic signed [16:0] oy;
		logic signed [16:0] ox;
		logic signed [15:0] cy;
		logic signed [15:0] cx;
		logic [21:0]        sum;
		logic [6:0]         count;
		logic [2:0]         status;
	} summary_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic                cfg_wdata;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [InWidth-1:0]  s_axis_tdata;
	logic                s_axis_tuser;
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	logic [OutWidth-1:0] m_axis_tdata;

	pixel_cluster_grower_top DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	// Cluster predictor state.
	logic [7:0]  mem_id[MembersMax];
	logic [5:0]  mem_col[MembersMax];
	logic [5:0]  mem_row[MembersMax];
	int          members;
	longint      amp_total;
	longint      wx_total;
	longint      wy_total;
	longint      lead_amp;
	longint      lead_x;
	longint      lead_y;
	logic        eight_conn;

	summary_t    expected_q[$];
	int          send_idle_pct;
	int          recv_stall_pct;
	int          hold_cycles;
	int          errors;
	int          sent;
	int          checked;
	int          full_seen;
	longint      cycles;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic logic touches(logic [5:0] col, logic [5:0] row);
		int dc;
		int dr;
		if (members == 0)
			return 1'b1;
		for (int i = 0; i < members; i++) begin
			dc = int'(mem_col[i]) - int'(col);
			dr = int'(mem_row[i]) - int'(row);
			if (dc < 0) dc = -dc;
			if (dr < 0) dr = -dr;
			if (!eight_conn && dc + dr == 1)
				return 1'b1;
			if (eight_conn && dc < 2 && dr < 2)
				return 1'b1;
		end
		return 1'b0;
	endfunction

	// Updates the cluster with one pixel and returns the summary it yields.
	function automatic summary_t grow_cluster(pixel_t p);
		summary_t s;
		logic [2:0] st;
		longint cx;
		longint cy;
		longint ratio;
		if (p.first)
			members = 0;
		if (p.first) begin
			amp_total = 0; wx_total = 0; wy_total = 0;
			lead_amp = 0; lead_x = 0; lead_y = 0;
		end
		st = pcg_pkg::StAccepted;
		if (p.id == 8'd0) begin
			st = pcg_pkg::StInvalidId;
		end else begin
			for (int i = 0; i < members; i++)
				if (mem_id[i] == p.id)
					st = pcg_pkg::StDuplicate;
			if (st == pcg_pkg::StAccepted && !touches(p.col, p.row))
				st = pcg_pkg::StNotNeighbour;
			if (st == pcg_pkg::StAccepted && members >= MembersMax)
				st = pcg_pkg::StStoreFull;
		end
		if (st == pcg_pkg::StAccepted) begin
			mem_id[members] = p.id;
			mem_col[members] = p.col;
			mem_row[members] = p.row;
			members++;
			amp_total += longint'(p.amp);
			wx_total += longint'(p.x) * longint'(p.amp);
			wy_total += longint'(p.y) * longint'(p.amp);
			if (members == 1 || longint'(p.amp) > lead_amp) begin
				lead_amp = p.amp;
				lead_x = p.x;
				lead_y = p.y;
			end
		end
		if (st == pcg_pkg::StStoreFull)
			full_seen++;
		s = '0;
		s.status = st;
		s.count = members[6:0];
		s.sum = amp_total[21:0];
		s.zero = 1'b1;
		if (members != 0 && amp_total != 0) begin
			cx = wx_total / amp_total;
			cy = wy_total / amp_total;
			ratio = (lead_amp << 16) / amp_total;
			if (ratio > 65535)
				ratio = 65535;
			s.zero = 1'b0;
			s.cx = cx[15:0];
			s.cy = cy[15:0];
			s.ox = 17'(cx - lead_x);
			s.oy = 17'(cy - lead_y);
			s.ratio = ratio[15:0];
		end
		return s;
	endfunction

	task automatic send_pixel(pixel_t p);
		if ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid = 1'b0;
			do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tuser = p.first;
		s_axis_tdata = '0;
		s_axis_tdata[67:0] = {p.amp, p.y, p.x, p.row, p.col, p.id};
		do @(posedge clk); while (!s_axis_tready);
		expected_q = {expected_q, grow_cluster(p)};
		sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid = 1'b0;
		wait (expected_q.size() == 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_pattern(logic val);
		drain();
		cfg_we = 1'b1;
		cfg_wdata = val;
		eight_conn = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	function automatic pixel_t make_pixel(int first, logic [7:0] id, int col, int row,
			int x, int y, int amp);
		pixel_t p;
		p.first = 1'(first);
		p.id = id;
		p.col = col[5:0];
		p.row = row[5:0];
		p.x = x[15:0];
		p.y = y[15:0];
		p.amp = amp[15:0];
		return p;
	endfunction

	task automatic test_directed();
		write_pattern(1'b0);
		send_pixel(make_pixel(1, 8'd0, 5, 5, 0, 0, 10));        // start with invalid id
		send_pixel(make_pixel(0, 8'd10, 63, 63, -32768, 32767, 0));
		send_pixel(make_pixel(0, 8'd11, 62, 63, 32767, -32768, 0)); // sum still zero
		send_pixel(make_pixel(0, 8'd12, 63, 62, 100, -100, 65535));
		send_pixel(make_pixel(0, 8'd13, 62, 62, -5, 7, 3));      // edge neighbour
		send_pixel(make_pixel(0, 8'd12, 61, 63, 1, 1, 1));       // duplicate id
		send_pixel(make_pixel(0, 8'd0, 61, 63, 1, 1, 1));
		send_pixel(make_pixel(0, 8'd255, 61, 63, -1, -1, 65535)); // tie keeps leader
		send_pixel(make_pixel(0, 8'd14, 63, 63, 9, 9, 5));       // same place, 4-conn
		send_pixel(make_pixel(1, 8'd1, 0, 0, -32768, -32768, 65535));
		send_pixel(make_pixel(0, 8'd2, 1, 0, -32768, -32768, 65535));
		send_pixel(make_pixel(0, 8'd3, 3, 0, 0, 0, 1));          // gap of two
		write_pattern(1'b1);
		send_pixel(make_pixel(0, 8'd4, 1, 0, 32767, 32767, 7));  // same place, 8-conn
		send_pixel(make_pixel(0, 8'd5, 2, 1, 32767, 32767, 65535));
		send_pixel(make_pixel(0, 8'd6, 4, 2, 0, 0, 1));
		send_pixel(make_pixel(0, 8'd7, 3, 2, -3, 3, 8));
		send_pixel(make_pixel(1, 8'd128, 32, 31, 12345, -12345, 1));
		send_pixel(make_pixel(0, 8'd127, 31, 32, -1, 1, 2));
		drain();
	endtask

	task automatic test_store_full();
		write_pattern(1'b0);
		// A serpentine of eight pixels per row keeps every pixel an edge neighbour.
		for (int i = 0; i < MembersMax + 1; i++) begin
			int r;
			int c;
			r = i / 8;
			c = (r % 2 == 0) ? i % 8 : 7 - i % 8;
			send_pixel(make_pixel(int'(i == 0), 8'(i + 1), c + 20, r + 40,
				$urandom_range(65535) - 32768, $urandom_range(65535) - 32768,
				$urandom_range(65535)));
		end
		drain();
	endtask

	function automatic pixel_t random_pixel();
		pixel_t p;
		int k;
		int r;
		p.x = 16'($urandom);
		p.y = 16'($urandom);
		r = $urandom_range(99);
		p.amp = (r < 5) ? 16'd0 : (r < 10) ? 16'hffff : 16'($urandom);
		p.first = (members == 0 || $urandom_range(99) < 2);
		r = $urandom_range(99);
		if (r < 4)
			p.id = 8'd0;
		else if (r < 10 && members > 0)
			p.id = mem_id[$urandom_range(members - 1)];
		else
			p.id = 8'($urandom_range(255, 1));
		if (p.first) begin
			p.col = 6'($urandom);
			p.row = 6'($urandom);
		end else begin
			k = $urandom_range(members - 1);
			p.col = mem_col[k] + 6'($urandom_range(2)) - 6'd1;
			p.row = mem_row[k] + 6'($urandom_range(2)) - 6'd1;
			if ($urandom_range(99) < 10)
				p.col = p.col + 6'd2;
		end
		return p;
	endfunction

	task automatic test_random(int idle_pct, int stall_pct, int n);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		write_pattern(1'($urandom_range(1)));
		for (int i = 0; i < n; i++) begin
			send_pixel(random_pixel());
			if (i == n / 2)
				write_pattern(~eight_conn);
		end
		drain();
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = 600;
		for (int i = 0; i < 12; i++)
			send_pixel(random_pixel());
		drain();
		for (int i = 0; i < 6; i++)
			send_pixel(random_pixel());
		drain();
	endtask

	// Receiver: random stalls plus an optional long hold-off.
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		summary_t got;
		summary_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[114:0];
			if (expected_q.size() == 0) begin
				$display("%0t: result with nothing expected, actual %h", $time, got);
				errors++;
			end else begin
				want = expected_q.pop_front();
				checked++;
				if (got.status !== want.status)
					$display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
				if (got.count !== want.count)
					$display("%0t: count expected %0d actual %0d", $time, want.count, got.count);
				if (got.sum !== want.sum)
					$display("%0t: sum expected %0d actual %0d", $time, want.sum, got.sum);
				if (got.cx !== want.cx)
					$display("%0t: centroid_x expected %0d actual %0d", $time, want.cx, got.cx);
				if (got.cy !== want.cy)
					$display("%0t: centroid_y expected %0d actual %0d", $time, want.cy, got.cy);
				if (got.ox !== want.ox)
					$display("%0t: offset_x expected %0d actual %0d", $time, want.ox, got.ox);
				if (got.oy !== want.oy)
					$display("%0t: offset_y expected %0d actual %0d", $time, want.oy, got.oy);
				if (got.ratio !== want.ratio)
					$display("%0t: ratio expected %0d actual %0d", $time, want.ratio, got.ratio);
				if (got.zero !== want.zero)
					$display("%0t: sum_is_zero expected %0d actual %0d", $time, want.zero,
						got.zero);
				if (got !== want)
					errors++;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("pixel_cluster_grower_top test failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		m_axis_tready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = 0;
		errors = 0;
		sent = 0;
		checked = 0;
		full_seen = 0;
		cycles = 0;
		members = 0;
		amp_total = 0; wx_total = 0; wy_total = 0;
		lead_amp = 0; lead_x = 0; lead_y = 0;
		eight_conn = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_store_full();
		test_random(0, 0, 400);
		test_random(78, 0, 350);
		test_random(0, 78, 350);
		test_random(8, 8, 350);
		test_backpressure();
		$display("Sent %0d pixels and checked %0d results, %0d of them store full,",
			sent, checked, full_seen);
		$display("under both neighbour rules and four idle and stall mixes.");
		if (errors == 0 && expected_q.size() == 0) begin
			$display("pixel_cluster_grower_top test passed");
		end else begin
			$display("pixel_cluster_grower_top test failed");
		end
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/pcg_pkg.sv
rtl/pcg_divider.sv
rtl/pcg_member_store.sv
rtl/pixel_cluster_grower_top.sv
rtl/pcg_checker.sv
test/pixel_cluster_grower_top_tb.sv
